// ===== design/scle_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial console line editor package
// Shared constants, codes and types for the line editor.
// ----------------------------------------------------------------------------
package scle_pkg;

    localparam int LINE_CAPACITY_DEF = 48;
    localparam int LEN_W = 6;

    localparam logic [1:0] KIND_TERM  = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;

    localparam logic [2:0] CMD_HELP   = 3'd0;
    localparam logic [2:0] CMD_PING   = 3'd1;
    localparam logic [2:0] CMD_LEDON  = 3'd2;
    localparam logic [2:0] CMD_LEDOFF = 3'd3;
    localparam logic [2:0] CMD_STATUS = 3'd4;
    localparam logic [2:0] CMD_ECHO   = 3'd5;
    localparam logic [2:0] CMD_SLEEP  = 3'd6;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_BADNUM  = 2'd2;
    localparam logic [1:0] ERR_TOOLONG = 2'd3;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_TLD = 8'h7E;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ECHO,
        ST_BS0,
        ST_BS1,
        ST_BS2,
        ST_CR,
        ST_LF,
        ST_SCAN,
        ST_PARSE,
        ST_EVENT,
        ST_TEXT,
        ST_PROMPT0,
        ST_PROMPT1
    } state_t;

    // Command word characters, indexed by position (up to seven characters).
    function automatic logic [7:0] word_char(input logic [2:0] cmd, input logic [2:0] pos);
        logic [55:0] w;
        begin
            case (cmd)
                CMD_HELP:   w = {"help", 24'h0};
                CMD_PING:   w = {"ping", 24'h0};
                CMD_LEDON:  w = {"led on", 8'h0};
                CMD_LEDOFF: w = "led off";
                CMD_STATUS: w = {"status", 8'h0};
                CMD_ECHO:   w = {"echo ", 16'h0};
                CMD_SLEEP:  w = {"sleep ", 8'h0};
                default:    w = '0;
            endcase
            word_char = w[55 - 8*pos -: 8];
        end
    endfunction

    function automatic logic [2:0] word_len(input logic [2:0] cmd);
        begin
            case (cmd)
                CMD_HELP:   word_len = 3'd4;
                CMD_PING:   word_len = 3'd4;
                CMD_LEDON:  word_len = 3'd6;
                CMD_LEDOFF: word_len = 3'd7;
                CMD_STATUS: word_len = 3'd6;
                CMD_ECHO:   word_len = 3'd5;
                CMD_SLEEP:  word_len = 3'd6;
                default:    word_len = 3'd0;
            endcase
        end
    endfunction

endpackage

// ===== design/serial_console_line_editor.sv =====
// ----------------------------------------------------------------------------
// Serial console line editor
// Edits a command line from received bytes and reports commands at line end.
// ----------------------------------------------------------------------------
// The input channel (rx_valid/rx_ready, rx_byte) takes one received byte per
// transfer. The output channel (out_valid/out_ready) delivers result items:
// echo bytes, line end bytes, one command event and its text bytes, and the
// prompt; last marks the final item caused by a byte.
// A printable byte is accepted in ST_IDLE and then echoed from ST_ECHO. A
// line end compares the stored line with the candidate command words in turn
// through one shared byte comparator, one character per cycle and only up to
// the word length. The sleep argument is then parsed one digit per cycle with
// a shift-and-add by ten. One byte is worked on at a time; rx_ready is low
// until all its results have been transferred.
// A stalled receiver holds the current result item; nothing is lost.
// Reset clears the line, the flags and the LED flag to off.
// ----------------------------------------------------------------------------
module serial_console_line_editor #(
    parameter int LINE_CAPACITY = scle_pkg::LINE_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [2:0]  command,
    output logic [1:0]  error,
    output logic [31:0] sleep_ms,
    output logic        led_state,
    output logic        last
);

    localparam int LW = scle_pkg::LEN_W;

    logic [7:0] mem [LINE_CAPACITY];
    logic [7:0] rd_data_reg;
    logic [LW-1:0] rd_addr;

    scle_pkg::state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic ovf_reg, ovf_next;
    logic acr_reg, acr_next;
    logic led_reg, led_next;
    logic [7:0] byte_reg, byte_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [1:0] err_reg, err_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic ok_reg, ok_next;
    logic [32:0] val_reg, val_next;
    logic wr_en;

    logic [2:0] wlen;
    logic [7:0] wch;
    logic [LW-1:0] idx_p1;
    logic [36:0] prod;
    logic [36:0] dsum;
    logic is_digit;

    assign wlen = scle_pkg::word_len(cmd_reg);
    assign wch = scle_pkg::word_char(cmd_reg, idx_reg[2:0]);
    assign idx_p1 = idx_reg + LW'(1);
    assign is_digit = (rd_data_reg >= "0") && (rd_data_reg <= "9");
    assign prod = {1'b0, val_reg[32:0], 3'b000} + {3'b000, val_reg[32:0], 1'b0};
    assign dsum = prod + {33'd0, rd_data_reg[3:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg] <= rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scle_pkg::ST_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            acr_reg   <= 1'b0;
            led_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            acr_reg   <= acr_next;
            led_reg   <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        cmd_reg  <= cmd_next;
        err_reg  <= err_next;
        idx_reg  <= idx_next;
        ok_reg   <= ok_next;
        val_reg  <= val_next;
    end

    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg;
        ovf_next = ovf_reg;
        acr_next = acr_reg;
        led_next = led_reg;
        byte_next = byte_reg;
        cmd_next = cmd_reg;
        err_next = err_reg;
        idx_next = idx_reg;
        ok_next = ok_reg;
        val_next = val_reg;
        wr_en = 1'b0;
        rd_addr = idx_reg;
        rx_ready = 1'b0;
        out_valid = 1'b0;
        kind = scle_pkg::KIND_TERM;
        data_byte = '0;
        command = scle_pkg::CMD_HELP;
        error = scle_pkg::ERR_NONE;
        sleep_ms = '0;
        last = 1'b0;
        led_state = led_reg;

        case (state_reg)
            scle_pkg::ST_IDLE:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    byte_next = rx_byte;
                    if (rx_byte == scle_pkg::CH_LF && acr_reg)
                    begin
                        acr_next = 1'b0;
                    end
                    else
                    begin
                        acr_next = (rx_byte == scle_pkg::CH_CR);
                        if (rx_byte == scle_pkg::CH_CR || rx_byte == scle_pkg::CH_LF)
                        begin
                            state_next = scle_pkg::ST_CR;
                        end
                        else if (rx_byte == scle_pkg::CH_BS || rx_byte == scle_pkg::CH_DEL)
                        begin
                            if (len_reg != '0 && !ovf_reg)
                            begin
                                len_next = len_reg - LW'(1);
                                state_next = scle_pkg::ST_BS0;
                            end
                        end
                        else if (rx_byte >= scle_pkg::CH_SP && rx_byte <= scle_pkg::CH_TLD)
                        begin
                            if (!ovf_reg && 32'(len_reg) < LINE_CAPACITY)
                            begin
                                wr_en = 1'b1;
                                len_next = len_reg + LW'(1);
                                state_next = scle_pkg::ST_ECHO;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                end
            end

            scle_pkg::ST_ECHO:
            begin
                out_valid = 1'b1;
                data_byte = byte_reg;
                last = 1'b1;
                if (out_ready)
                begin
                    state_next = scle_pkg::ST_IDLE;
                end
            end

            scle_pkg::ST_BS0, scle_pkg::ST_BS1, scle_pkg::ST_BS2:
            begin
                out_valid = 1'b1;
                data_byte = (state_reg == scle_pkg::ST_BS1) ? scle_pkg::CH_SP
                                                            : scle_pkg::CH_BS;
                last = (state_reg == scle_pkg::ST_BS2);
                if (out_ready)
                begin
                    case (state_reg)
                        scle_pkg::ST_BS0: state_next = scle_pkg::ST_BS1;
                        scle_pkg::ST_BS1: state_next = scle_pkg::ST_BS2;
                        default:          state_next = scle_pkg::ST_IDLE;
                    endcase
                end
            end

            scle_pkg::ST_CR:
            begin
                out_valid = 1'b1;
                data_byte = scle_pkg::CH_CR;
                if (out_ready)
                begin
                    state_next = scle_pkg::ST_LF;
                end
            end

            scle_pkg::ST_LF:
            begin
                out_valid = 1'b1;
                data_byte = scle_pkg::CH_LF;
                cmd_next = scle_pkg::CMD_HELP;
                idx_next = '0;
                ok_next = 1'b1;
                rd_addr = '0;
                if (out_ready)
                begin
                    if (ovf_reg)
                    begin
                        err_next = scle_pkg::ERR_TOOLONG;
                        state_next = scle_pkg::ST_EVENT;
                    end
                    else if (len_reg == '0)
                    begin
                        state_next = scle_pkg::ST_PROMPT0;
                    end
                    else
                    begin
                        err_next = scle_pkg::ERR_NONE;
                        state_next = scle_pkg::ST_SCAN;
                    end
                end
            end

            // One character compare per cycle against the current candidate.
            scle_pkg::ST_SCAN:
            begin
                if (idx_reg == LW'(wlen) || !ok_reg)
                begin
                    if (ok_reg && (cmd_reg >= scle_pkg::CMD_ECHO || len_reg == LW'(wlen))
                        && len_reg >= LW'(wlen))
                    begin
                        idx_next = LW'(wlen);
                        if (cmd_reg == scle_pkg::CMD_SLEEP)
                        begin
                            val_next = '0;
                            ok_next = (len_reg > LW'(wlen));
                            rd_addr = LW'(wlen);
                            state_next = scle_pkg::ST_PARSE;
                        end
                        else
                        begin
                            if (cmd_reg == scle_pkg::CMD_LEDON)
                            begin
                                led_next = 1'b1;
                            end
                            if (cmd_reg == scle_pkg::CMD_LEDOFF)
                            begin
                                led_next = 1'b0;
                            end
                            rd_addr = LW'(wlen);
                            state_next = scle_pkg::ST_EVENT;
                        end
                    end
                    else if (cmd_reg == scle_pkg::CMD_SLEEP)
                    begin
                        err_next = scle_pkg::ERR_UNKNOWN;
                        cmd_next = scle_pkg::CMD_HELP;
                        idx_next = '0;
                        rd_addr = '0;
                        state_next = scle_pkg::ST_EVENT;
                    end
                    else
                    begin
                        cmd_next = cmd_reg + 3'd1;
                        idx_next = '0;
                        ok_next = 1'b1;
                        rd_addr = '0;
                    end
                end
                else
                begin
                    if (idx_reg >= len_reg || rd_data_reg != wch)
                    begin
                        ok_next = 1'b0;
                    end
                    idx_next = idx_p1;
                    rd_addr = idx_p1;
                end
            end

            // One decimal digit per cycle.
            scle_pkg::ST_PARSE:
            begin
                if (!ok_reg || idx_reg >= len_reg)
                begin
                    if (ok_reg)
                    begin
                        state_next = scle_pkg::ST_EVENT;
                    end
                    else
                    begin
                        err_next = scle_pkg::ERR_BADNUM;
                        cmd_next = scle_pkg::CMD_HELP;
                        idx_next = LW'(6);
                        rd_addr = LW'(6);
                        state_next = scle_pkg::ST_EVENT;
                    end
                end
                else
                begin
                    if (!is_digit || dsum[36:32] != '0)
                    begin
                        ok_next = 1'b0;
                    end
                    val_next = {1'b0, dsum[31:0]};
                    idx_next = idx_p1;
                    rd_addr = idx_p1;
                end
            end

            scle_pkg::ST_EVENT:
            begin
                out_valid = 1'b1;
                kind = scle_pkg::KIND_EVENT;
                command = cmd_reg;
                error = err_reg;
                sleep_ms = (cmd_reg == scle_pkg::CMD_SLEEP && err_reg == scle_pkg::ERR_NONE)
                           ? val_reg[31:0] : 32'd0;
                if (out_ready)
                begin
                    if ((err_reg == scle_pkg::ERR_NONE && cmd_reg == scle_pkg::CMD_ECHO)
                        || err_reg == scle_pkg::ERR_UNKNOWN
                        || err_reg == scle_pkg::ERR_BADNUM)
                    begin
                        state_next = scle_pkg::ST_TEXT;
                    end
                    else
                    begin
                        state_next = scle_pkg::ST_PROMPT0;
                    end
                end
            end

            scle_pkg::ST_TEXT:
            begin
                if (idx_reg >= len_reg)
                begin
                    state_next = scle_pkg::ST_PROMPT0;
                end
                else
                begin
                    out_valid = 1'b1;
                    kind = scle_pkg::KIND_TEXT;
                    data_byte = rd_data_reg;
                    if (out_ready)
                    begin
                        idx_next = idx_p1;
                        rd_addr = idx_p1;
                    end
                end
            end

            scle_pkg::ST_PROMPT0:
            begin
                out_valid = 1'b1;
                data_byte = scle_pkg::CH_GT;
                len_next = '0;
                ovf_next = 1'b0;
                if (out_ready)
                begin
                    state_next = scle_pkg::ST_PROMPT1;
                end
            end

            scle_pkg::ST_PROMPT1:
            begin
                out_valid = 1'b1;
                data_byte = scle_pkg::CH_SP;
                last = 1'b1;
                if (out_ready)
                begin
                    state_next = scle_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = scle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/scle_checker.sv =====
// ----------------------------------------------------------------------------
// Serial console line editor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module scle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  data_byte,
    input logic [2:0]  command,
    input logic [1:0]  error,
    input logic [31:0] sleep_ms
);

    // The block never takes a byte while a result is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_ready && out_valid))
        else $error("input taken while a result is pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(kind))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= scle_pkg::KIND_TEXT)
        else $error("bad kind");

    // Error events and non-event items carry CMD_HELP as their command code.
    a_err_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != scle_pkg::KIND_EVENT || error != scle_pkg::ERR_NONE)
        |-> command == scle_pkg::CMD_HELP)
        else $error("command set on error or non-event");

    a_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != scle_pkg::CMD_SLEEP |-> sleep_ms == 32'd0)
        else $error("sleep value outside a sleep event");

endmodule

bind serial_console_line_editor scle_checker u_scle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_ready  (rx_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .command   (command),
    .error     (error),
    .sleep_ms  (sleep_ms)
);
